// ===== sv/vt4_pkg.sv =====
package vt4_pkg;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int REG_W     = 64;
  localparam int COMP_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * COMP_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SHR_W     = SUM_W - FRAC_BITS;

  typedef enum logic {
    KIND_MAT_VEC = 1'b0,
    KIND_VEC_MAT = 1'b1
  } kind_t;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_regs_t;
  typedef logic [3:0][COMP_W-1:0]         vec_t;

  typedef logic [3:0][3:0][PROD_W-1:0]    prod_t;
  typedef logic [3:0][1:0][PAIR_W-1:0]    pair_t;
  typedef logic [3:0][SUM_W-1:0]          sum_t;

  localparam mat_regs_t REG_RESET = '{
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  function automatic logic [COMP_W-1:0] mat_entry(input mat_regs_t regs, input logic [3:0] idx);
    logic [REG_W-1:0] word;
    word = regs[idx[3:1]];
    return idx[0] ? word[REG_W-1:COMP_W] : word[COMP_W-1:0];
  endfunction

endpackage

// ===== sv/vt4_mul.sv =====
module vt4_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  vt4_pkg::mat_regs_t mat_regs,
  input  logic               in_valid,
  output logic               in_ready,
  input  vt4_pkg::kind_t     in_kind,
  input  vt4_pkg::vec_t      in_vec,
  output logic               out_valid,
  input  logic               out_ready,
  output vt4_pkg::prod_t     out_prod
);
  import vt4_pkg::*;

  logic  valid_r;
  prod_t prod_r;
  prod_t prod_nxt;
  logic  adv;

  assign adv      = ~valid_r | out_ready;
  assign in_ready = adv;

  always_comb begin
    logic [COMP_W-1:0] m;
    logic [3:0]        idx;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (in_kind == KIND_VEC_MAT) begin
          idx = 4'(4 * r + c);
        end else begin
          idx = 4'(4 * c + r);
        end
        m = mat_entry(mat_regs, idx);
        prod_nxt[r][c] = PROD_W'($signed(m) * $signed(in_vec[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = prod_r;

endmodule

// ===== sv/vt4_sum.sv =====
module vt4_sum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vt4_pkg::prod_t in_prod,
  output logic           out_valid,
  input  logic           out_ready,
  output vt4_pkg::sum_t  out_sum
);
  import vt4_pkg::*;

  logic  pair_valid_r;
  pair_t pair_r;
  pair_t pair_nxt;
  logic  sum_valid_r;
  sum_t  sum_r;
  sum_t  sum_nxt;
  logic  pair_adv;
  logic  sum_adv;

  assign sum_adv  = ~sum_valid_r | out_ready;
  assign pair_adv = ~pair_valid_r | sum_adv;
  assign in_ready = pair_adv;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int h = 0; h < 2; h++) begin
        pair_nxt[r][h] = PAIR_W'($signed(in_prod[r][2*h])) +
                         PAIR_W'($signed(in_prod[r][2*h+1]));
      end
      sum_nxt[r] = SUM_W'($signed(pair_r[r][0])) + SUM_W'($signed(pair_r[r][1]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else begin
      if (pair_adv) begin
        pair_valid_r <= in_valid;
      end
      if (sum_adv) begin
        sum_valid_r <= pair_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_adv && in_valid) begin
      pair_r <= pair_nxt;
    end
    if (sum_adv && pair_valid_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = sum_valid_r;
  assign out_sum   = sum_r;

endmodule

// ===== sv/vt4_sat.sv =====
module vt4_sat (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vt4_pkg::sum_t in_sum,
  output logic          out_valid,
  input  logic          out_ready,
  output vt4_pkg::vec_t out_vec,
  output logic          out_clip
);
  import vt4_pkg::*;

  logic valid_r;
  vec_t vec_r;
  vec_t vec_nxt;
  logic clip_r;
  logic clip_nxt;
  logic adv;

  assign adv      = ~valid_r | out_ready;
  assign in_ready = adv;

  always_comb begin
    logic [SHR_W-1:0] shr;
    logic             ovf;
    clip_nxt = 1'b0;
    for (int r = 0; r < 4; r++) begin
      shr = in_sum[r][SUM_W-1:FRAC_BITS];
      // fits when the bits above the result sign all copy it
      ovf = ~((&shr[SHR_W-1:COMP_W-1]) | ~(|shr[SHR_W-1:COMP_W-1]));
      if (!ovf) begin
        vec_nxt[r] = shr[COMP_W-1:0];
      end else if (shr[SHR_W-1]) begin
        vec_nxt[r] = {1'b1, {(COMP_W-1){1'b0}}};
      end else begin
        vec_nxt[r] = {1'b0, {(COMP_W-1){1'b1}}};
      end
      clip_nxt = clip_nxt | ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      vec_r  <= vec_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;
  assign out_clip  = clip_r;

endmodule

// ===== sv/vertex_transform_4x4.sv =====
// Transforms one Q16.16 homogeneous vertex per cycle by a stored 4x4 column-major
// matrix (tuser 0: M*v, tuser 1: v*M), from request to result through sixteen
// 32x32 multipliers, two adder levels and a saturation stage, each registered.
// Results are floor-shifted by 16 and saturated to 32 bits; tuser on the output
// flags saturation of any component. Each stage holds its request on
// a stall and takes a new one whenever it drains, so the throughput is one
// vertex per cycle while out_tready stays high. The matrix resets to identity;
// write it through cfg_ only while no request is in flight. Indices past the
// eighth register are ignored.
module vertex_transform_4x4 (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [vt4_pkg::REG_W-1:0]              cfg_data,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [4*vt4_pkg::COMP_W-1:0]           in_tdata,  // vec_x, vec_y, vec_z, vec_w
  input  logic                                   in_tuser,  // kind
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [4*vt4_pkg::COMP_W-1:0]           out_tdata, // out_x, out_y, out_z, out_w
  output logic                                   out_tuser  // clipped
);
  import vt4_pkg::*;

  mat_regs_t mat_r;
  vec_t      in_vec;
  kind_t     in_kind;
  logic      mul_valid;
  logic      mul_ready;
  prod_t     mul_prod;
  logic      sum_valid;
  logic      sum_ready;
  sum_t      sum_val;
  vec_t      sat_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= REG_RESET;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      mat_r[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  assign in_vec  = in_tdata;
  assign in_kind = kind_t'(in_tuser);

  vt4_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_regs  (mat_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_kind),
    .in_vec    (in_vec),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_prod  (mul_prod)
  );

  vt4_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_prod   (mul_prod),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_sum   (sum_val)
  );

  vt4_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_sum    (sum_val),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_vec   (sat_vec),
    .out_clip  (out_tuser)
  );

  assign out_tdata = sat_vec;

endmodule
